// File: rtl/wsr_pkg.sv
// Shared types and constants for the winch sequencer with recovery.
// Used by wsr_step and winch_sequencer_with_recovery; depends on nothing.
package wsr_pkg;

  localparam int unsigned MaxDepthPoints = 16;
  localparam int unsigned PointWidth     = 5;
  localparam int unsigned AttemptWidth   = 3;
  localparam int unsigned CfgIndexWidth  = 3;
  localparam int unsigned CfgDataWidth   = 5;
  localparam int unsigned FuncWidth      = 3;
  localparam int unsigned StateWidth     = 4;
  localparam int unsigned TimerWidth     = 3;

  localparam logic [PointWidth-1:0]   PointMax   = {PointWidth{1'b1}};
  localparam logic [AttemptWidth-1:0] AttemptMax = {AttemptWidth{1'b1}};

  typedef enum logic [StateWidth-1:0] {
    ST_IDLE  = 4'd0,
    ST_DOWN  = 4'd1,
    ST_UP    = 4'd2,
    ST_WAIT  = 4'd3,
    ST_DONE  = 4'd4,
    ST_ERR   = 4'd5,
    ST_TREV  = 4'd6,
    ST_RDOWN = 4'd7,
    ST_RUP   = 4'd8
  } op_state_t;

  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_UP      = 2'd1,
    DIR_DOWN    = 2'd2,
    DIR_INVALID = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_HOME     = 3'd2,
    EV_ALARM    = 3'd3,
    EV_CLEAR    = 3'd4,
    EV_AUTO_OFF = 3'd5,
    EV_TIMEOUT  = 3'd6
  } event_t;

  typedef enum logic [FuncWidth-1:0] {
    FN_START   = 3'd0,
    FN_HOME    = 3'd1,
    FN_TENSION = 3'd2,
    FN_AUTO    = 3'd3,
    FN_TIMER   = 3'd4
  } func_t;

  typedef enum logic [TimerWidth-1:0] {
    TK_NONE  = 3'd0,
    TK_MOVE  = 3'd1,
    TK_WAIT  = 3'd2,
    TK_1S    = 3'd3,
    TK_2S    = 3'd4,
    TK_8S    = 3'd5
  } timer_kind_t;

  typedef enum logic [1:0] {
    MODE_LOWER = 2'd0,
    MODE_RISE  = 2'd1,
    MODE_HOME  = 2'd2
  } mode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_OPERATION_MODE  = 3'd0,
    CFG_DEPTH_STOPS     = 3'd1,
    CFG_POINT_COUNT     = 3'd2,
    CFG_RECOVERY_LIMIT  = 3'd3
  } cfg_index_t;

  typedef struct packed {
    mode_t                   mode;
    logic                    depth_stops;
    logic [PointWidth-1:0]   point_count;
    logic [AttemptWidth-1:0] recovery_limit;
  } cfg_t;

  typedef struct packed {
    op_state_t               st;
    dir_t                    dir;
    logic [AttemptWidth-1:0] attempt;
    logic [PointWidth-1:0]   pidx;
  } ctx_t;

  typedef struct packed {
    logic [StateWidth-1:0] op_state;
    logic                  drive_down;
    logic                  drive_up;
    logic [TimerWidth-1:0] timer_kind;
    logic                  done_res;
    logic                  failed;
  } res_t;

endpackage

// File: rtl/wsr_step.sv
// Combinational transition logic of the winch sequencer: event decode, state
// change with entry actions, counters and the result word. Uses wsr_pkg.
module wsr_step #(
  parameter int unsigned MAX_DEPTH_POINTS = wsr_pkg::MaxDepthPoints
) (
  input  wsr_pkg::cfg_t                   cfg,
  input  wsr_pkg::ctx_t                   cur,
  input  logic [wsr_pkg::FuncWidth-1:0]   func,
  input  logic                            level,
  input  logic                            tension_now,
  output wsr_pkg::ctx_t                   nxt,
  output wsr_pkg::res_t                   res
);
  import wsr_pkg::*;

  localparam logic [PointWidth-1:0] PointLimit = PointWidth'(MAX_DEPTH_POINTS);

  event_t                  ev;
  op_state_t               move_st;
  op_state_t               hnext;
  logic [PointWidth-1:0]   points_in_use;
  logic [PointWidth-1:0]   pidx_inc;
  logic [PointWidth-1:0]   pidx_h;
  logic                    at_static;
  logic [AttemptWidth-1:0] att_h;
  logic [AttemptWidth-1:0] att_inc;

  always_comb begin
    unique case (func_t'(func))
      FN_START:   ev = EV_START;
      FN_HOME:    ev = level ? EV_HOME : EV_NONE;
      FN_TENSION: ev = level ? EV_ALARM : EV_CLEAR;
      FN_AUTO:    ev = level ? EV_NONE : EV_AUTO_OFF;
      FN_TIMER:   ev = EV_TIMEOUT;
      default:    ev = EV_NONE;
    endcase
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_LOWER:          move_st = ST_DOWN;
      MODE_RISE, MODE_HOME: move_st = ST_UP;
      default:             move_st = ST_ERR;
    endcase
  end

  assign points_in_use = (cfg.point_count > PointLimit) ? PointLimit : cfg.point_count;
  assign at_static     = cfg.depth_stops && (cur.pidx < points_in_use);
  assign pidx_inc      = (cur.pidx < PointMax) ? cur.pidx + 1'b1 : cur.pidx;

  // Event handling: the state the event asks for, before entry actions.
  always_comb begin
    hnext  = cur.st;
    att_h  = cur.attempt;
    pidx_h = cur.pidx;
    unique case (cur.st)
      ST_IDLE, ST_DONE, ST_ERR: begin
        if (ev == EV_START) begin
          att_h  = '0;
          pidx_h = '0;
          hnext  = move_st;
        end
      end
      ST_DOWN: begin
        priority if (ev == EV_HOME) hnext = ST_DONE;
        else if (ev == EV_ALARM) hnext = ST_TREV;
        else if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_TIMEOUT) begin
          if (at_static) hnext = ST_WAIT;
          else hnext = (cfg.mode == MODE_LOWER) ? ST_DONE : ST_ERR;
        end
        else hnext = cur.st;
      end
      ST_UP: begin
        priority if (ev == EV_HOME) hnext = ST_DONE;
        else if (ev == EV_ALARM) hnext = ST_TREV;
        else if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_TIMEOUT) hnext = at_static ? ST_WAIT : ST_RDOWN;
        else hnext = cur.st;
      end
      ST_WAIT: begin
        priority if (ev == EV_HOME && cfg.mode == MODE_RISE) hnext = ST_DONE;
        else if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_TIMEOUT) begin
          pidx_h = pidx_inc;
          if (pidx_inc >= points_in_use) begin
            hnext = (cfg.mode == MODE_RISE) ? ST_UP : ST_DONE;
          end else begin
            hnext = move_st;
          end
        end
        else hnext = cur.st;
      end
      ST_TREV: begin
        priority if (ev == EV_HOME) hnext = ST_DONE;
        else if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_CLEAR) hnext = move_st;
        else if (ev == EV_TIMEOUT) hnext = tension_now ? ST_ERR : move_st;
        else hnext = cur.st;
      end
      ST_RDOWN: begin
        priority if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_TIMEOUT) hnext = ST_RUP;
        else hnext = cur.st;
      end
      ST_RUP: begin
        priority if (ev == EV_HOME) hnext = ST_DONE;
        else if (ev == EV_AUTO_OFF) hnext = ST_ERR;
        else if (ev == EV_TIMEOUT) begin
          hnext = (cur.attempt >= cfg.recovery_limit) ? ST_ERR : ST_RDOWN;
        end
        else hnext = cur.st;
      end
      default: hnext = ST_IDLE;
    endcase
  end

  assign att_inc = (att_h < AttemptMax) ? att_h + 1'b1 : att_h;

  // Entry actions, taken only when the state actually changes; a done or error state always stops the winch.
  always_comb begin
    nxt.st      = hnext;
    nxt.dir     = cur.dir;
    nxt.attempt = att_h;
    nxt.pidx    = pidx_h;
    if (hnext != cur.st) begin
      unique case (hnext)
        ST_IDLE, ST_WAIT: nxt.dir = DIR_STOP;
        ST_DOWN:          nxt.dir = DIR_DOWN;
        ST_UP, ST_RUP:    nxt.dir = DIR_UP;
        ST_TREV:          nxt.dir = (cur.dir == DIR_DOWN) ? DIR_UP : DIR_DOWN;
        ST_RDOWN: begin
          nxt.attempt = att_inc;
          if (att_inc > cfg.recovery_limit) begin
            nxt.dir = DIR_STOP;
            nxt.st  = ST_ERR;
          end else begin
            nxt.dir = DIR_DOWN;
          end
        end
        default:          nxt.dir = DIR_STOP;
      endcase
    end
    if (nxt.st == ST_DONE || nxt.st == ST_ERR) begin
      nxt.dir = DIR_STOP;
    end
  end

  always_comb begin
    res.op_state   = nxt.st;
    res.drive_down = (nxt.dir == DIR_DOWN);
    res.drive_up   = (nxt.dir == DIR_UP);
    res.done_res   = (nxt.st == ST_DONE);
    res.failed     = (nxt.st == ST_ERR);
    unique case (nxt.st)
      ST_DOWN, ST_UP: res.timer_kind = TK_MOVE;
      ST_WAIT:        res.timer_kind = TK_WAIT;
      ST_TREV:        res.timer_kind = TK_1S;
      ST_RDOWN:       res.timer_kind = TK_2S;
      ST_RUP:         res.timer_kind = TK_8S;
      default:        res.timer_kind = TK_NONE;
    endcase
  end

endmodule

// File: rtl/winch_sequencer_with_recovery.sv
// Top level of the winch sequencer with timeout and tension recovery.
// Holds configuration, sequencer state and the output buffer; uses wsr_pkg and wsr_step.
//
// Each accepted event word is handled in the clock cycle it is accepted: the
// transition logic in wsr_step is combinational from the state registers, so
// a new event can be taken on every clock while in_stall is low. A two-word
// output buffer registers each result word and lets the block take one more event
// while a result is stalled; in_stall rises only when both words are held.
module winch_sequencer_with_recovery #(
  parameter int unsigned MAX_DEPTH_POINTS = wsr_pkg::MaxDepthPoints
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsr_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [wsr_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wsr_pkg::FuncWidth-1:0]       func,
  input  logic                                level,
  input  logic                                tension_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wsr_pkg::StateWidth-1:0]      op_state,
  output logic                                drive_down,
  output logic                                drive_up,
  output logic [wsr_pkg::TimerWidth-1:0]      timer_kind,
  output logic                                done_res,
  output logic                                failed
);
  import wsr_pkg::*;

  cfg_t cfg;
  ctx_t ctx;
  ctx_t ctx_next;
  res_t res_next;
  res_t out_word;
  res_t skid_word;
  logic skid_full;
  logic accept;
  logic take;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;
  assign in_stall  = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_HOME;
      cfg.depth_stops    <= 1'b0;
      cfg.point_count    <= '0;
      cfg.recovery_limit <= AttemptWidth'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OPERATION_MODE: cfg.mode           <= mode_t'(cfg_data[1:0]);
        CFG_DEPTH_STOPS:    cfg.depth_stops    <= cfg_data[0];
        CFG_POINT_COUNT:    cfg.point_count    <= cfg_data[PointWidth-1:0];
        CFG_RECOVERY_LIMIT: cfg.recovery_limit <= cfg_data[AttemptWidth-1:0];
        default: ;
      endcase
    end
  end

  wsr_step #(
    .MAX_DEPTH_POINTS(MAX_DEPTH_POINTS)
  ) u_step (
    .cfg         (cfg),
    .cur         (ctx),
    .func        (func),
    .level       (level),
    .tension_now (tension_now),
    .nxt         (ctx_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.st      <= ST_IDLE;
      ctx.dir     <= DIR_INVALID;
      ctx.attempt <= '0;
      ctx.pidx    <= '0;
    end else if (accept) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        out_word <= skid_word;
      end
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_word <= res_next;
      end else begin
        out_word <= res_next;
      end
    end
  end

  assign op_state   = out_word.op_state;
  assign drive_down = out_word.drive_down;
  assign drive_up   = out_word.drive_up;
  assign timer_kind = out_word.timer_kind;
  assign done_res   = out_word.done_res;
  assign failed     = out_word.failed;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Second buffer word held without a first one.");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("Second buffer word filled while the output was free.");

  a_one_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_down && drive_up))
    else $error("Both winch lines driven at once.");

  a_terminal_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (done_res || failed)) |-> (!drive_down && !drive_up))
    else $error("Winch driven in a terminal state.");

  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((timer_kind == TK_NONE) ==
      (op_state == ST_IDLE || op_state == ST_DONE || op_state == ST_ERR)))
    else $error("Timer request does not match the state.");

endmodule

// File: bench/testbench.sv
// Self-checking bench for winch_sequencer_with_recovery.
// Drives event words and register writes, predicts each result word, and
// compares it with the block's output; depends on wsr_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wsr_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;

  class winch_scoreboard;
    logic [1:0]              mode;
    logic                    depth_stops;
    logic [PointWidth-1:0]   npoints;
    logic [AttemptWidth-1:0] rlimit;
    op_state_t               st;
    dir_t                    dir;
    logic [AttemptWidth-1:0] attempts;
    logic [PointWidth-1:0]   pidx;
    res_t                    pending_results[$];
    int unsigned             mismatches;
    int unsigned             checked;

    function new();
      mode         = MODE_HOME;
      depth_stops  = 1'b0;
      npoints      = '0;
      rlimit       = 3'd3;
      st           = ST_IDLE;
      dir          = DIR_INVALID;
      attempts     = '0;
      pidx         = '0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CfgDataWidth-1:0] d);
      case (idx)
        CFG_OPERATION_MODE: mode = d[1:0];
        CFG_DEPTH_STOPS:    depth_stops = d[0];
        CFG_POINT_COUNT:    npoints = d[PointWidth-1:0];
        CFG_RECOVERY_LIMIT: rlimit = d[AttemptWidth-1:0];
        default: ;
      endcase
    endfunction

    function op_state_t travel_state();
      if (mode == MODE_LOWER) return ST_DOWN;
      if (mode == MODE_RISE || mode == MODE_HOME) return ST_UP;
      return ST_ERR;
    endfunction

    function logic [PointWidth-1:0] points_used();
      return (npoints > MaxDepthPoints) ? PointWidth'(MaxDepthPoints) : npoints;
    endfunction

    function bit at_point();
      return depth_stops && (pidx < points_used());
    endfunction

    function event_t decode(logic [FuncWidth-1:0] f, logic lv);
      case (f)
        FN_START:   return EV_START;
        FN_HOME:    return lv ? EV_HOME : EV_NONE;
        FN_TENSION: return lv ? EV_ALARM : EV_CLEAR;
        FN_AUTO:    return lv ? EV_NONE : EV_AUTO_OFF;
        FN_TIMER:   return EV_TIMEOUT;
        default:    return EV_NONE;
      endcase
    endfunction

    function op_state_t transition(event_t ev, logic tn);
      case (st)
        ST_IDLE, ST_DONE, ST_ERR: begin
          if (ev == EV_START) begin
            attempts = '0;
            pidx = '0;
            return travel_state();
          end
        end
        ST_DOWN: begin
          if (ev == EV_HOME) return ST_DONE;
          if (ev == EV_ALARM) return ST_TREV;
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_TIMEOUT) begin
            if (at_point()) return ST_WAIT;
            return (mode == MODE_LOWER) ? ST_DONE : ST_ERR;
          end
        end
        ST_UP: begin
          if (ev == EV_HOME) return ST_DONE;
          if (ev == EV_ALARM) return ST_TREV;
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_TIMEOUT) return at_point() ? ST_WAIT : ST_RDOWN;
        end
        ST_WAIT: begin
          if (ev == EV_HOME && mode == MODE_RISE) return ST_DONE;
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_TIMEOUT) begin
            if (pidx != PointMax) pidx++;
            if (pidx >= points_used()) return (mode == MODE_RISE) ? ST_UP : ST_DONE;
            return travel_state();
          end
        end
        ST_TREV: begin
          if (ev == EV_HOME) return ST_DONE;
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_CLEAR) return travel_state();
          if (ev == EV_TIMEOUT) return tn ? ST_ERR : travel_state();
        end
        ST_RDOWN: begin
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_TIMEOUT) return ST_RUP;
        end
        ST_RUP: begin
          if (ev == EV_HOME) return ST_DONE;
          if (ev == EV_AUTO_OFF) return ST_ERR;
          if (ev == EV_TIMEOUT) return (attempts >= rlimit) ? ST_ERR : ST_RDOWN;
        end
        default: return ST_IDLE;
      endcase
      return st;
    endfunction

    function op_state_t enter(op_state_t nx);
      case (nx)
        ST_IDLE, ST_WAIT: dir = DIR_STOP;
        ST_DOWN:          dir = DIR_DOWN;
        ST_UP, ST_RUP:    dir = DIR_UP;
        ST_TREV:          dir = (dir == DIR_DOWN) ? DIR_UP : DIR_DOWN;
        ST_RDOWN: begin
          if (attempts != AttemptMax) attempts++;
          if (attempts > rlimit) begin
            dir = DIR_STOP;
            return ST_ERR;
          end
          dir = DIR_DOWN;
        end
        default: dir = DIR_STOP;
      endcase
      return nx;
    endfunction

    function timer_kind_t timer_of(op_state_t s);
      case (s)
        ST_DOWN, ST_UP: return TK_MOVE;
        ST_WAIT:        return TK_WAIT;
        ST_TREV:        return TK_1S;
        ST_RDOWN:       return TK_2S;
        ST_RUP:         return TK_8S;
        default:        return TK_NONE;
      endcase
    endfunction

    // Returns whether the word changed anything in the sequencer.
    function bit note_event(logic [FuncWidth-1:0] f, logic lv, logic tn);
      event_t    ev;
      op_state_t prev;
      op_state_t nx;
      res_t      r;
      ev = decode(f, lv);
      prev = st;
      nx = transition(ev, tn);
      if (nx != prev) nx = enter(nx);
      if (nx == ST_DONE || nx == ST_ERR) dir = DIR_STOP;
      st = nx;
      r.op_state   = nx;
      r.drive_down = (dir == DIR_DOWN);
      r.drive_up   = (dir == DIR_UP);
      r.timer_kind = timer_of(nx);
      r.done_res   = (nx == ST_DONE);
      r.failed     = (nx == ST_ERR);
      pending_results.push_back(r);
      return (nx != prev) ||
             (ev == EV_START && (prev == ST_IDLE || prev == ST_DONE || prev == ST_ERR));
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word st=%0d dn=%0b up=%0b tk=%0d done=%0b fail=%0b",
                   $time, got.op_state, got.drive_down, got.drive_up, got.timer_kind,
                   got.done_res, got.failed);
        return;
      end
      want = pending_results.pop_front();
      if (got.op_state !== want.op_state || got.drive_down !== want.drive_down ||
          got.drive_up !== want.drive_up || got.timer_kind !== want.timer_kind ||
          got.done_res !== want.done_res || got.failed !== want.failed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected st=%0d dn=%0b up=%0b tk=%0d done=%0b fail=%0b",
                   $time, want.op_state, want.drive_down, want.drive_up, want.timer_kind,
                   want.done_res, want.failed);
          $display("  got st=%0d dn=%0b up=%0b tk=%0d done=%0b fail=%0b",
                   got.op_state, got.drive_down, got.drive_up, got.timer_kind,
                   got.done_res, got.failed);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [FuncWidth-1:0]     func;
  logic                     level;
  logic                     tension_now;
  logic                     out_valid;
  logic                     out_stall;
  logic [StateWidth-1:0]    op_state;
  logic                     drive_down;
  logic                     drive_up;
  logic [TimerWidth-1:0]    timer_kind;
  logic                     done_res;
  logic                     failed;

  winch_scoreboard winch_sb;
  bit              gaps_on;
  bit              squeeze;
  int unsigned     words_sent;
  int unsigned     words_effective;
  int unsigned     settings_used;

  winch_sequencer_with_recovery dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .level       (level),
    .tension_now (tension_now),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .op_state    (op_state),
    .drive_down  (drive_down),
    .drive_up    (drive_up),
    .timer_kind  (timer_kind),
    .done_res    (done_res),
    .failed      (failed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      winch_sb.check_result({op_state, drive_down, drive_up, timer_kind, done_res, failed});
  end

  // The receiver counts its own long hold-off once the stimulus asks for one.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (squeeze) begin
        squeeze = 1'b0;
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic send_word(input logic [FuncWidth-1:0] f, input logic lv, input logic tn);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    level       <= lv;
    tension_now <= tn;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (winch_sb.note_event(f, lv, tn)) words_effective++;
  endtask

  task automatic send_shaped();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      send_word(FN_TIMER, 1'($urandom_range(1)), $urandom_range(3) == 0);
    else if (pick < 70)
      send_word(FN_TENSION, 1'($urandom_range(1)), 1'($urandom_range(1)));
    else if (pick < 80)
      send_word(FN_HOME, $urandom_range(3) == 0, 1'($urandom_range(1)));
    else if (pick < 88)
      send_word(FN_AUTO, $urandom_range(3) != 0, 1'($urandom_range(1)));
    else if (pick < 92)
      send_word(FN_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
    else
      send_word(3'($urandom_range(7, FN_TIMER + 1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned target;
    target = words_sent + quota;
    while (words_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_word(FN_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat ($urandom_range(4, 30)) send_shaped();
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (winch_sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    winch_sb.set_reg(idx, d);
  endtask

  // Unused upper data bits are randomized; the block must ignore them.
  task automatic apply_config(input logic [1:0] m, input logic s, input logic [4:0] np,
                              input logic [2:0] rl);
    write_reg(CFG_OPERATION_MODE, {3'($urandom), m});
    write_reg(CFG_DEPTH_STOPS, {4'($urandom), s});
    write_reg(CFG_POINT_COUNT, np);
    write_reg(CFG_RECOVERY_LIMIT, {2'($urandom), rl});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned phase;
    winch_sb        = new();
    gaps_on         = 1'b1;
    squeeze         = 1'b0;
    words_sent      = 0;
    words_effective = 0;
    settings_used   = 1;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_OPERATION_MODE;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    func        <= FN_START;
    level       <= 1'b0;
    tension_now <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under the reset settings (going home, limit of three).
    send_word(FN_TIMER, 1'b0, 1'b1);
    send_word(3'(FN_TIMER + 2), 1'b1, 1'b0);
    send_word(3'(FN_TIMER + 3), 1'b1, 1'b1);
    send_word(FN_START, 1'b0, 1'b0);
    send_word(FN_START, 1'b1, 1'b1);
    send_word(FN_HOME, 1'b0, 1'b0);
    send_word(FN_AUTO, 1'b1, 1'b0);
    send_word(FN_TENSION, 1'b1, 1'b0);
    send_word(FN_TIMER, 1'b0, 1'b1);
    send_word(FN_START, 1'b0, 1'b0);
    send_word(FN_TENSION, 1'b1, 1'b1);
    send_word(FN_TENSION, 1'b0, 1'b0);
    send_word(FN_TENSION, 1'b1, 1'b0);
    send_word(FN_TIMER, 1'b1, 1'b0);
    repeat (7) send_word(FN_TIMER, 1'b0, 1'b0);
    send_word(FN_START, 1'b0, 1'b0);
    send_word(FN_AUTO, 1'b0, 1'b1);
    send_word(FN_START, 1'b0, 1'b0);
    send_word(FN_HOME, 1'b1, 1'b0);
    settle();

    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: apply_config(MODE_LOWER, 1'b1, 5'd2, 3'd3);
        1: apply_config(MODE_RISE, 1'b1, 5'd20, 3'd7);
        2: apply_config(MODE_HOME, 1'b0, 5'd0, 3'd1);
        3: apply_config(MODE_RISE, 1'b0, 5'd31, 3'd0);
        4: apply_config(ModeUnused, 1'b1, 5'd1, 3'd7);
        5: apply_config(MODE_HOME, 1'b1, 5'd16, 3'd2);
        6: apply_config(MODE_LOWER, 1'b1, 5'd16, 3'd7);
        default: apply_config(2'($urandom_range(2)), 1'($urandom_range(1)),
                              5'($urandom_range(31)), 3'($urandom_range(7)));
      endcase
      gaps_on = (phase != 2);
      if (phase == 1 || phase == 6) squeeze = 1'b1;
      run_random((phase == 4) ? 40 : 125);
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Summary: %0d event words (%0d that moved the sequencer), %0d results checked,",
             words_sent, words_effective, winch_sb.checked);
    $display("  across %0d register settings including all modes and limit extremes.",
             settings_used);
    if (winch_sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
